// ----- rtl/sm83_pkg.sv -----
// Package for the SM83 first-quadrant executor: field codes and flag positions.
// No dependencies.
`timescale 1ns / 1ps
package sm83_pkg;
  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_READ  = 2'd1;
  localparam logic [1:0] MEM_WRITE = 2'd2;

  localparam logic [1:0] FAULT_OK    = 2'd0;
  localparam logic [1:0] FAULT_UNSUP = 2'd1;
  localparam logic [1:0] FAULT_STOP  = 2'd2;

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_LDA  = 2'd1;
  localparam logic [1:0] PEND_INC  = 2'd2;
  localparam logic [1:0] PEND_DEC  = 2'd3;

  localparam int FZ = 3;
  localparam int FN = 2;
  localparam int FH = 1;
  localparam int FC = 0;

  localparam logic KIND_INSTR = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [7:0]  acc;
    logic [3:0]  flag_nibble;
    logic [1:0]  mem_op;
    logic [15:0] mem_address;
    logic [7:0]  mem_write_data;
    logic [1:0]  fault;
    logic        last;
  } result_t;
endpackage

// ----- rtl/sm83_first_quadrant_executor.sv -----
// Channel   Direction  Signals
// input     in         in_valid_i/in_ready_o, kind_i opcode_i imm_low_i imm_high_i read_data_i
// result    out        out_valid_o/out_ready_i, next_pc_o acc_o flag_nibble_o mem_op_o ...
// One item per cycle when the output does not stall: the architectural state updates
// in the accept cycle and the result is registered for output. LD (a16),SP yields two
// results and holds off input while the second waits in its slot. The output register
// and its second slot stall together with the consumer. Reset clears the architectural
// state and the valid flags; the result data registers are not reset.
// Depends on sm83_pkg.
`timescale 1ns / 1ps
module sm83_first_quadrant_executor
  import sm83_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  opcode_i,
  input  logic [7:0]  imm_low_i,
  input  logic [7:0]  imm_high_i,
  input  logic [7:0]  read_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] next_pc_o,
  output logic [7:0]  acc_o,
  output logic [3:0]  flag_nibble_o,
  output logic [1:0]  mem_op_o,
  output logic [15:0] mem_address_o,
  output logic [7:0]  mem_write_data_o,
  output logic [1:0]  fault_o,
  output logic        last_o
);
  logic [7:0]  regs_q [7];
  logic [7:0]  regs_d [7];
  logic [3:0]  f_q, f_d;
  logic [15:0] sp_q, sp_d, pc_q, pc_d;
  logic [1:0]  pend_q, pend_d;
  logic [15:0] paddr_q, paddr_d;
  result_t     res0, res1, out_q, sec_q;
  logic        two;
  logic        ov_q, sv_q;
  logic        acc_in;

  assign in_ready_o = !sv_q && (!ov_q || out_ready_i);
  assign acc_in = in_valid_i && in_ready_o;

  function automatic logic [15:0] pget(input logic [1:0] p, input logic [7:0] r [7],
                                       input logic [15:0] sp);
    case (p)
      2'd0:    pget = {r[0], r[1]};
      2'd1:    pget = {r[2], r[3]};
      2'd2:    pget = {r[4], r[5]};
      default: pget = sp;
    endcase
  endfunction

  always_comb begin
    logic [15:0] n16, hl, npc, s, addr;
    logic [16:0] sum;
    logic [1:0]  p;
    logic [2:0]  r, ri;
    logic [7:0]  a, v, dres;
    logic [1:0]  mop;
    logic [15:0] maddr, pv;
    logic [7:0]  mdata;
    logic [1:0]  len;
    logic        take, wp, dc;
    for (int i = 0; i < 7; i++) regs_d[i] = regs_q[i];
    f_d = f_q; sp_d = sp_q; pc_d = pc_q; pend_d = pend_q; paddr_d = paddr_q;
    n16 = {imm_high_i, imm_low_i};
    hl = {regs_q[4], regs_q[5]};
    a = regs_q[6];
    p = opcode_i[5:4];
    r = opcode_i[5:3];
    ri = (r == 3'd7) ? 3'd6 : r;
    mop = MEM_NONE; maddr = '0; mdata = '0;
    two = 1'b0; v = '0; s = '0; sum = '0; addr = '0; dres = '0; dc = 1'b0;
    take = 1'b0; wp = 1'b0; pv = '0;
    res0 = '0; res1 = '0;
    if (kind_i == KIND_READ) begin
      pend_d = PEND_NONE;
      if (pend_q == PEND_LDA) begin
        regs_d[6] = read_data_i;
      end else if (pend_q != PEND_NONE) begin
        if (pend_q == PEND_INC) begin
          v = read_data_i + 8'd1;
          f_d = {v == 8'd0, 1'b0, read_data_i[3:0] == 4'hF, f_q[FC]};
        end else begin
          v = read_data_i - 8'd1;
          f_d = {v == 8'd0, 1'b1, read_data_i[3:0] == 4'h0, f_q[FC]};
        end
        mop = MEM_WRITE; maddr = paddr_q; mdata = v;
      end
      res0 = '{pc_q, regs_d[6], f_d, mop, maddr, mdata, FAULT_OK, 1'b1};
    end else if (opcode_i[7:6] != 2'b00) begin
      pend_d = PEND_NONE;
      res0 = '{pc_q, a, f_q, MEM_NONE, 16'd0, 8'd0, FAULT_UNSUP, 1'b1};
    end else if (opcode_i == 8'h10 && imm_low_i != 8'd0) begin
      pend_d = PEND_NONE;
      res0 = '{pc_q, a, f_q, MEM_NONE, 16'd0, 8'd0, FAULT_STOP, 1'b1};
    end else begin
      pend_d = PEND_NONE;
      if (opcode_i[2:0] == 3'd6 || opcode_i == 8'h10 || opcode_i == 8'h18
          || (opcode_i & 8'hE7) == 8'h20) len = 2'd2;
      else if (opcode_i[3:0] == 4'h1 || opcode_i == 8'h08) len = 2'd3;
      else len = 2'd1;
      npc = pc_q + {14'd0, len};
      pv = pget(p, regs_q, sp_q);
      case (opcode_i[3:0])
        4'h1, 4'h3, 4'hB, 4'h9, 4'h2, 4'hA: begin
          wp = 1'b1;
          case (opcode_i[3:0])
            4'h1: s = n16;
            4'h3: s = pv + 16'd1;
            4'hB: s = pv - 16'd1;
            4'h9: begin
              sum = {1'b0, hl} + {1'b0, pv};
              f_d = {f_q[FZ], 1'b0, ({1'b0, hl[11:0]} + {1'b0, pv[11:0]}) > 13'h0FFF, sum[16]};
              s = sum[15:0];
            end
            default: begin
              addr = (p == 2'd0) ? {regs_q[0], regs_q[1]} :
                     (p == 2'd1) ? {regs_q[2], regs_q[3]} : hl;
              if (opcode_i[3]) begin
                pend_d = PEND_LDA; paddr_d = addr; mop = MEM_READ; maddr = addr;
              end else begin
                mop = MEM_WRITE; maddr = addr; mdata = a;
              end
              wp = p[1];
              s = p[0] ? hl - 16'd1 : hl + 16'd1;
            end
          endcase
          if (wp) begin
            if (opcode_i[3:0] == 4'h2 || opcode_i[3:0] == 4'hA || opcode_i[3:0] == 4'h9) begin
              regs_d[4] = s[15:8]; regs_d[5] = s[7:0];
            end else begin
              case (p)
                2'd0: begin regs_d[0] = s[15:8]; regs_d[1] = s[7:0]; end
                2'd1: begin regs_d[2] = s[15:8]; regs_d[3] = s[7:0]; end
                2'd2: begin regs_d[4] = s[15:8]; regs_d[5] = s[7:0]; end
                default: sp_d = s;
              endcase
            end
          end
        end
        4'h4, 4'hC, 4'h5, 4'hD, 4'h6, 4'hE: begin
          if (r == 3'd6) begin
            if (opcode_i[2:0] == 3'd6) begin
              mop = MEM_WRITE; maddr = hl; mdata = imm_low_i;
            end else begin
              pend_d = (opcode_i[2:0] == 3'd4) ? PEND_INC : PEND_DEC;
              paddr_d = hl; mop = MEM_READ; maddr = hl;
            end
          end else begin
            v = regs_q[ri];
            if (opcode_i[2:0] == 3'd4) begin
              dres = v + 8'd1;
              f_d = {dres == 8'd0, 1'b0, v[3:0] == 4'hF, f_q[FC]};
            end else if (opcode_i[2:0] == 3'd5) begin
              dres = v - 8'd1;
              f_d = {dres == 8'd0, 1'b1, v[3:0] == 4'h0, f_q[FC]};
            end else begin
              dres = imm_low_i;
            end
            regs_d[ri] = dres;
          end
        end
        default: ;
      endcase
      case (opcode_i)
        8'h07: begin f_d = {3'b000, a[7]}; regs_d[6] = {a[6:0], a[7]}; end
        8'h0F: begin f_d = {3'b000, a[0]}; regs_d[6] = {a[0], a[7:1]}; end
        8'h17: begin f_d = {3'b000, a[7]}; regs_d[6] = {a[6:0], f_q[FC]}; end
        8'h1F: begin f_d = {3'b000, a[0]}; regs_d[6] = {f_q[FC], a[7:1]}; end
        8'h27: begin
          dres = a; dc = f_q[FC];
          if (f_q[FN]) begin
            if (f_q[FC]) dres = dres - 8'h60;
            if (f_q[FH]) dres = dres - 8'h06;
          end else begin
            if (f_q[FC] || a > 8'h99) begin dres = dres + 8'h60; dc = 1'b1; end
            if (f_q[FH] || a[3:0] > 4'h9) dres = dres + 8'h06;
          end
          regs_d[6] = dres;
          f_d = {dres == 8'd0, f_q[FN], 1'b0, dc};
        end
        8'h2F: begin regs_d[6] = ~a; f_d = f_q | 4'b0110; end
        8'h37: f_d = {f_q[FZ], 3'b001};
        8'h3F: f_d = {f_q[FZ], 2'b00, ~f_q[FC]};
        8'h18, 8'h20, 8'h28, 8'h30, 8'h38: begin
          case (opcode_i)
            8'h20:   take = !f_q[FZ];
            8'h28:   take = f_q[FZ];
            8'h30:   take = !f_q[FC];
            8'h38:   take = f_q[FC];
            default: take = 1'b1;
          endcase
          if (take) npc = npc + {{8{imm_low_i[7]}}, imm_low_i};
        end
        8'h08: begin
          two = 1'b1;
          mop = MEM_WRITE; maddr = n16; mdata = sp_q[7:0];
        end
        default: ;
      endcase
      pc_d = npc;
      res0 = '{npc, regs_d[6], f_d, mop, maddr, mdata, FAULT_OK, !two};
      res1 = '{npc, regs_d[6], f_d, MEM_WRITE, n16 + 16'd1, sp_q[15:8], FAULT_OK, 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 7; i++) regs_q[i] <= '0;
      f_q <= '0; sp_q <= '0; pc_q <= '0; pend_q <= PEND_NONE; paddr_q <= '0;
      ov_q <= 1'b0; sv_q <= 1'b0;
    end else begin
      if (acc_in) begin
        for (int i = 0; i < 7; i++) regs_q[i] <= regs_d[i];
        f_q <= f_d; sp_q <= sp_d; pc_q <= pc_d; pend_q <= pend_d; paddr_q <= paddr_d;
        ov_q <= 1'b1; sv_q <= two;
      end else if (ov_q && out_ready_i) begin
        ov_q <= sv_q; sv_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      out_q <= res0; sec_q <= res1;
    end else if (ov_q && out_ready_i && sv_q) begin
      out_q <= sec_q;
    end
  end

  assign out_valid_o      = ov_q;
  assign next_pc_o        = out_q.next_pc;
  assign acc_o            = out_q.acc;
  assign flag_nibble_o    = out_q.flag_nibble;
  assign mem_op_o         = out_q.mem_op;
  assign mem_address_o    = out_q.mem_address;
  assign mem_write_data_o = out_q.mem_write_data;
  assign fault_o          = out_q.fault;
  assign last_o           = out_q.last;
endmodule

// ----- rtl/sm83_checker.sv -----
// Port-level checker for the SM83 first-quadrant executor, bound to the executor module.
// Depends on sm83_pkg.
`timescale 1ns / 1ps
module sm83_checker
  import sm83_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  mem_op_o,
  input logic [1:0]  fault_o,
  input logic        last_o
);
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(last_o) && out_valid_o) else $error("stall");
  a_fault_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fault_o != FAULT_OK |-> mem_op_o == MEM_NONE && last_o) else $error("fault");
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> mem_op_o == MEM_WRITE && !in_ready_o) else $error("pair");
  a_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o) else $error("resp");
endmodule

bind sm83_first_quadrant_executor sm83_checker u_chk (.*);

// ----- verif/tb_sm83_first_quadrant_executor.sv -----
// Testbench for sm83_first_quadrant_executor: drives instruction and read-return items
// under random idling and a long output hold-off, and checks every result against a
// built-in SM83 predictor. Depends on sm83_pkg and the executor RTL.
`timescale 1ns / 1ps
module tb_sm83_first_quadrant_executor;
  import sm83_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [7:0] opcode;
    logic [7:0] imm_low;
    logic [7:0] imm_high;
    logic [7:0] read_data;
  } instr_item_t;

  localparam int RB = 0, RC = 1, RD = 2, RE = 3, RHH = 4, RLL = 5, RACC = 6;
  localparam int CYCLE_LIMIT = 400000;

  int mismatches = 0;

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  class cpu_scoreboard;
    logic [7:0]  regs [7];
    logic [3:0]  flags;
    logic [15:0] sp, pc;
    logic [1:0]  pend_op;
    logic [15:0] pend_addr;
    result_t     expected_results [$];
    int          results_seen;

    function new();
      foreach (regs[i]) regs[i] = 8'h00;
      flags = 4'h0; sp = 16'h0; pc = 16'h0;
      pend_op = PEND_NONE; pend_addr = 16'h0; results_seen = 0;
    endfunction

    function logic [15:0] get_pair(input logic [1:0] p);
      case (p)
        2'd0: return {regs[RB], regs[RC]};
        2'd1: return {regs[RD], regs[RE]};
        2'd2: return {regs[RHH], regs[RLL]};
        default: return sp;
      endcase
    endfunction

    function void set_pair(input logic [1:0] p, input logic [15:0] v);
      case (p)
        2'd0: {regs[RB], regs[RC]} = v;
        2'd1: {regs[RD], regs[RE]} = v;
        2'd2: {regs[RHH], regs[RLL]} = v;
        default: sp = v;
      endcase
    endfunction

    function logic [7:0] inc_byte(input logic [7:0] v);
      logic [7:0] r;
      r = v + 8'd1;
      flags = {r == 8'd0, 1'b0, v[3:0] == 4'hF, flags[FC]};
      return r;
    endfunction

    function logic [7:0] dec_byte(input logic [7:0] v);
      logic [7:0] r;
      r = v - 8'd1;
      flags = {r == 8'd0, 1'b1, v[3:0] == 4'h0, flags[FC]};
      return r;
    endfunction

    function void push(input logic [1:0] mop, input logic [15:0] addr, input logic [7:0] data,
                       input logic [1:0] flt, input logic lst);
      result_t e;
      e.next_pc = pc; e.acc = regs[RACC]; e.flag_nibble = flags; e.mem_op = mop;
      e.mem_address = addr; e.mem_write_data = data; e.fault = flt; e.last = lst;
      expected_results.push_back(e);
    endfunction

    function void note_item(input instr_item_t it);
      logic [7:0]  op, lo, a, v;
      logic [15:0] n16, npc, hl, s, addr;
      logic [16:0] sum;
      logic [1:0]  p, mop, pend;
      logic [2:0]  r;
      logic [15:0] maddr;
      logic [7:0]  mdata, res;
      logic        take, c;
      int          len, idx;
      op = it.opcode; lo = it.imm_low; n16 = {it.imm_high, it.imm_low};
      mop = MEM_NONE; maddr = 16'h0; mdata = 8'h0;
      if (it.kind == KIND_READ) begin
        pend = pend_op; pend_op = PEND_NONE;
        if (pend == PEND_LDA) regs[RACC] = it.read_data;
        else if (pend == PEND_INC || pend == PEND_DEC) begin
          v = (pend == PEND_INC) ? inc_byte(it.read_data) : dec_byte(it.read_data);
          mop = MEM_WRITE; maddr = pend_addr; mdata = v;
        end
        push(mop, maddr, mdata, FAULT_OK, 1'b1);
        return;
      end
      pend_op = PEND_NONE;
      if (op >= 8'h40) begin push(MEM_NONE, 16'h0, 8'h0, FAULT_UNSUP, 1'b1); return; end
      if (op == 8'h10 && lo != 8'h0) begin
        push(MEM_NONE, 16'h0, 8'h0, FAULT_STOP, 1'b1);
        return;
      end
      if (op[2:0] == 3'd6 || op == 8'h10 || op == 8'h18 || (op & 8'hE7) == 8'h20) len = 2;
      else if (op[3:0] == 4'h1 || op == 8'h08) len = 3;
      else len = 1;
      npc = pc + 16'(len);
      r = op[5:3]; p = op[5:4]; a = regs[RACC]; hl = get_pair(2'd2);
      case (op[3:0])
        4'h1: set_pair(p, n16);
        4'h3: set_pair(p, get_pair(p) + 16'd1);
        4'hB: set_pair(p, get_pair(p) - 16'd1);
        4'h9: begin
          s = get_pair(p); sum = {1'b0, hl} + {1'b0, s};
          flags = {flags[FZ], 1'b0, ({1'b0, hl[11:0]} + {1'b0, s[11:0]}) > 13'h0FFF, sum[16]};
          set_pair(2'd2, sum[15:0]);
        end
        4'h2, 4'hA: begin
          addr = (p == 2'd0) ? get_pair(0) : (p == 2'd1) ? get_pair(1) : hl;
          if (p == 2'd2) set_pair(2'd2, hl + 16'd1);
          if (p == 2'd3) set_pair(2'd2, hl - 16'd1);
          mop = op[3] ? MEM_READ : MEM_WRITE; maddr = addr;
          if (op[3]) begin pend_op = PEND_LDA; pend_addr = addr; end
          else mdata = a;
        end
        4'h4, 4'hC, 4'h5, 4'hD, 4'h6, 4'hE: begin
          if (r == 3'd6) begin
            if (op[2:0] == 3'd6) begin mop = MEM_WRITE; maddr = hl; mdata = lo; end
            else begin
              pend_op = (op[2:0] == 3'd4) ? PEND_INC : PEND_DEC;
              pend_addr = hl; mop = MEM_READ; maddr = hl;
            end
          end else begin
            idx = (r == 3'd7) ? RACC : int'(r);
            if (op[2:0] == 3'd4) regs[idx] = inc_byte(regs[idx]);
            else if (op[2:0] == 3'd5) regs[idx] = dec_byte(regs[idx]);
            else regs[idx] = lo;
          end
        end
        default: ;
      endcase
      case (op)
        8'h07: begin flags = {3'b0, a[7]}; regs[RACC] = {a[6:0], a[7]}; end
        8'h0F: begin flags = {3'b0, a[0]}; regs[RACC] = {a[0], a[7:1]}; end
        8'h17: begin c = flags[FC]; flags = {3'b0, a[7]}; regs[RACC] = {a[6:0], c}; end
        8'h1F: begin c = flags[FC]; flags = {3'b0, a[0]}; regs[RACC] = {c, a[7:1]}; end
        8'h27: begin
          res = a; c = flags[FC];
          if (flags[FN]) begin
            if (flags[FC]) res = res - 8'h60;
            if (flags[FH]) res = res - 8'h06;
          end else begin
            if (flags[FC] || a > 8'h99) begin res = res + 8'h60; c = 1'b1; end
            if (flags[FH] || a[3:0] > 4'h9) res = res + 8'h06;
          end
          regs[RACC] = res; flags = {res == 8'h0, flags[FN], 1'b0, c};
        end
        8'h2F: begin regs[RACC] = ~a; flags[FN] = 1'b1; flags[FH] = 1'b1; end
        8'h37: flags = {flags[FZ], 3'b001};
        8'h3F: flags = {flags[FZ], 2'b00, ~flags[FC]};
        8'h18, 8'h20, 8'h28, 8'h30, 8'h38: begin
          take = 1'b1;
          if (op == 8'h20) take = !flags[FZ];
          if (op == 8'h28) take = flags[FZ];
          if (op == 8'h30) take = !flags[FC];
          if (op == 8'h38) take = flags[FC];
          if (take) npc = npc + {{8{lo[7]}}, lo};
        end
        8'h08: begin
          pc = npc;
          push(MEM_WRITE, n16, sp[7:0], FAULT_OK, 1'b0);
          push(MEM_WRITE, n16 + 16'd1, sp[15:8], FAULT_OK, 1'b1);
          return;
        end
        default: ;
      endcase
      pc = npc;
      push(mop, maddr, mdata, FAULT_OK, 1'b1);
    endfunction

    task check_result(input result_t got);
      result_t e;
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", got.next_pc, 16'h0);
        return;
      end
      e = expected_results.pop_front();
      if (got.next_pc != e.next_pc) report_mismatch("next_pc", got.next_pc, e.next_pc);
      if (got.acc != e.acc) report_mismatch("acc", 16'(got.acc), 16'(e.acc));
      if (got.flag_nibble != e.flag_nibble)
        report_mismatch("flag_nibble", 16'(got.flag_nibble), 16'(e.flag_nibble));
      if (got.mem_op != e.mem_op) report_mismatch("mem_op", 16'(got.mem_op), 16'(e.mem_op));
      if (got.mem_address != e.mem_address)
        report_mismatch("mem_address", got.mem_address, e.mem_address);
      if (got.mem_write_data != e.mem_write_data)
        report_mismatch("mem_write_data", 16'(got.mem_write_data), 16'(e.mem_write_data));
      if (got.fault != e.fault) report_mismatch("fault", 16'(got.fault), 16'(e.fault));
      if (got.last != e.last) report_mismatch("last", 16'(got.last), 16'(e.last));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        kind_i = 1'b0;
  logic [7:0]  opcode_i = 8'h0, imm_low_i = 8'h0, imm_high_i = 8'h0, read_data_i = 8'h0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] next_pc_o, mem_address_o;
  logic [7:0]  acc_o, mem_write_data_o;
  logic [3:0]  flag_nibble_o;
  logic [1:0]  mem_op_o, fault_o;
  logic        last_o;

  sm83_first_quadrant_executor dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  cpu_scoreboard board = new();
  int  cycle_count = 0;
  int  items_sent = 0;
  int  hold_off = 0;
  bit  calm_stretch = 1'b0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[sm83_first_quadrant_executor] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_result({next_pc_o, acc_o, flag_nibble_o, mem_op_o, mem_address_o,
                          mem_write_data_o, fault_o, last_o});
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm_stretch || ($urandom_range(99) >= 9);
    end
  end

  task automatic send_item(input instr_item_t it);
    if (!calm_stretch)
      while ($urandom_range(99) < 9) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    in_valid_i <= 1'b1;
    {kind_i, opcode_i, imm_low_i, imm_high_i, read_data_i} <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_item(it);
    items_sent++;
  endtask

  function automatic instr_item_t make_instr(input logic [7:0] op, input logic [7:0] lo,
                                             input logic [7:0] hi);
    return '{KIND_INSTR, op, lo, hi, 8'($urandom)};
  endfunction

  function automatic instr_item_t make_return(input logic [7:0] data);
    return '{KIND_READ, 8'($urandom), 8'($urandom), 8'($urandom), data};
  endfunction

  task automatic run_random(input int count);
    int          pick;
    logic [7:0]  op;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      op = 8'($urandom_range(8'h3F));
      if (pick < 6) send_item(make_instr(8'($urandom), 8'($urandom), 8'($urandom)));
      else if (pick < 10) send_item(make_return(8'($urandom)));
      else if (pick < 14) send_item(make_instr(8'h10, $urandom_range(1) ? 8'h00 : 8'($urandom),
                                               8'($urandom)));
      else begin
        send_item(make_instr(op, 8'($urandom), 8'($urandom)));
        if ((op[3:0] == 4'hA || op == 8'h34 || op == 8'h35) && $urandom_range(9) != 0)
          send_item(make_return(8'($urandom)));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(make_return(8'h55));
    send_item(make_instr(8'h31, 8'hFF, 8'hFF));
    send_item(make_instr(8'h08, 8'hFF, 8'hFF));
    send_item(make_instr(8'h21, 8'hFF, 8'hFF));
    send_item(make_instr(8'h23, 8'h00, 8'h00));
    send_item(make_instr(8'h39, 8'h00, 8'h00));
    send_item(make_instr(8'h3E, 8'h9A, 8'h00));
    send_item(make_instr(8'h27, 8'h00, 8'h00));
    send_item(make_instr(8'h3D, 8'h00, 8'h00));
    send_item(make_instr(8'h3C, 8'h00, 8'h00));
    send_item(make_instr(8'h0F, 8'h00, 8'h00));
    send_item(make_instr(8'h1F, 8'h00, 8'h00));
    send_item(make_instr(8'h07, 8'h00, 8'h00));
    send_item(make_instr(8'h17, 8'h00, 8'h00));
    send_item(make_instr(8'h2F, 8'h00, 8'h00));
    send_item(make_instr(8'h37, 8'h00, 8'h00));
    send_item(make_instr(8'h3F, 8'h00, 8'h00));
    send_item(make_instr(8'h18, 8'h80, 8'h00));
    send_item(make_instr(8'h20, 8'h7F, 8'h00));
    send_item(make_instr(8'h10, 8'h00, 8'h00));
    send_item(make_instr(8'h10, 8'h01, 8'h00));
    send_item(make_instr(8'hFF, 8'h00, 8'h00));
    send_item(make_instr(8'h34, 8'h00, 8'h00));
    send_item(make_return(8'hFF));
    send_item(make_instr(8'h3A, 8'h00, 8'h00));
    send_item(make_instr(8'h35, 8'h00, 8'h00));
    send_item(make_return(8'h00));

    hold_off <= 300;
    run_random(600);
    calm_stretch <= 1'b1;
    run_random(400);
    calm_stretch <= 1'b0;
    run_random(800);

    in_valid_i <= 1'b0;
    while (board.expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d items and checked %0d results, with a long output stall.",
             items_sent, board.results_seen);
    if (mismatches == 0 && board.expected_results.size() == 0)
      $display("[sm83_first_quadrant_executor] OK");
    else
      $display("[sm83_first_quadrant_executor] ERROR");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/sm83_pkg.sv
rtl/sm83_first_quadrant_executor.sv
rtl/sm83_checker.sv
verif/tb_sm83_first_quadrant_executor.sv
